### sv/kcc_pkg.sv
// Shared types, codes and constants for the key chord combo detector.
`timescale 1ns / 1ps

package kcc_pkg;

	// Fixed field widths
	localparam int MaskW   = 32;
	localparam int KeyW    = 10;
	localparam int SlotW   = 5;
	localparam int StatusW = 2;
	localparam int OpW     = 2;

	// Depth of the job queue between front and back
	localparam int QueueDepth = 4;

	// Parameter defaults
	localparam int DefaultNumKeys   = 512;
	localparam int DefaultNumCombos = 32;

	// Input opcodes
	localparam logic [OpW-1:0] OP_DEFINE  = 2'd0;
	localparam logic [OpW-1:0] OP_PRESS   = 2'd1;
	localparam logic [OpW-1:0] OP_RELEASE = 2'd2;

	// Define status codes
	localparam logic [StatusW-1:0] ST_OK        = 2'd0;
	localparam logic [StatusW-1:0] ST_SLOT_USED = 2'd1;
	localparam logic [StatusW-1:0] ST_KEY_RANGE = 2'd2;
	localparam logic [StatusW-1:0] ST_SAME_KEY  = 2'd3;

	// Kind of work handed to the back end
	typedef enum logic [1:0] {
		JOB_SINGLE,
		JOB_PRESS,
		JOB_RELEASE
	} job_kind_t;

	// One queued job: a single result, or a scan over combo bits
	typedef struct packed {
		job_kind_t            kind;
		logic [KeyW-1:0]      key;
		logic                 down;
		logic                 cork;
		logic [StatusW-1:0]   status;
		logic [MaskW-1:0]     bits;
		logic [MaskW-1:0]     full;
	} job_t;

	// Front end states
	typedef enum logic [2:0] {
		F_IDLE,
		F_KEY,
		F_DEF,
		F_DEF_RD,
		F_DEF_SEC
	} front_state_t;

	// Back end states
	typedef enum logic [3:0] {
		B_IDLE,
		B_ONE,
		B_NEXT,
		B_P_FIRST,
		B_P_SECOND,
		B_P_COMBO,
		B_R_RDA,
		B_R_RDB,
		B_R_COMBO,
		B_R_A,
		B_R_B
	} back_state_t;

endpackage

### sv/kcc_front.sv
// Front end: accepts items, owns all combo state and the key memory, queues jobs.
`timescale 1ns / 1ps

module kcc_front #(
	parameter int NUM_KEYS   = kcc_pkg::DefaultNumKeys,
	parameter int NUM_COMBOS = kcc_pkg::DefaultNumCombos
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic [kcc_pkg::OpW-1:0]                      opcode,
	input  logic [kcc_pkg::KeyW-1:0]                     key,
	input  logic [kcc_pkg::KeyW-1:0]                     second_key,
	input  logic [kcc_pkg::SlotW-1:0]                    combo_index,
	output logic                                         push,
	output kcc_pkg::job_t                                push_job,
	input  logic                                         q_full,
	input  logic                                         back_idle,
	input  logic [$clog2(NUM_KEYS)-1:0]                  back_raddr,
	output logic [kcc_pkg::MaskW-1:0]                    back_rdata,
	input  logic [((NUM_COMBOS > 1) ? $clog2(NUM_COMBOS) : 1)-1:0] back_combo,
	output logic [$clog2(NUM_KEYS)-1:0]                  pair_first_key,
	output logic [$clog2(NUM_KEYS)-1:0]                  pair_second_key
);
	import kcc_pkg::*;

	localparam int KW    = $clog2(NUM_KEYS);
	localparam int CW    = (NUM_COMBOS > 1) ? $clog2(NUM_COMBOS) : 1;
	localparam int WordW = MaskW + 1;
	localparam logic [KeyW-1:0]  KeyLimit  = KeyW'(NUM_KEYS);
	localparam logic [SlotW:0]   SlotLimit = (SlotW + 1)'(NUM_COMBOS);
	localparam logic [KW-1:0]    LastAddr  = KW'(NUM_KEYS - 1);

	// Key memory word: {pressed, combo mask}
	logic [WordW-1:0] mem [NUM_KEYS];
	logic [WordW-1:0] rdata_q;
	logic [MaskW-1:0] back_rdata_q;
	logic             we;
	logic [KW-1:0]    waddr;
	logic [KW-1:0]    raddr;
	logic [WordW-1:0] wdata;

	// Item registers
	logic [OpW-1:0]   op_q;
	logic [KeyW-1:0]  key_q;
	logic [KeyW-1:0]  second_q;
	logic [SlotW-1:0] slot_q;

	// Control and combo state
	front_state_t     fst_q, fst_d;
	logic             clearing_q;
	logic [KW-1:0]    clr_cnt_q;
	logic [MaskW-1:0] alloc_q;
	logic [MaskW-1:0] half_q;
	logic [MaskW-1:0] full_q;
	logic [KW-1:0]    pair_first_q  [NUM_COMBOS];
	logic [KW-1:0]    pair_second_q [NUM_COMBOS];

	// Actions decided by the output block
	logic             set_alloc;
	logic             set_first;
	logic             set_second;
	logic             set_masks;
	logic [MaskW-1:0] half_d;
	logic [MaskW-1:0] full_d;
	job_t             job;

	// Classification terms
	logic             word_pressed;
	logic [MaskW-1:0] word_mask;
	logic             key_ok;
	logic             sec_ok;
	logic             slot_ok;
	logic [MaskW-1:0] slot_bit;
	logic [CW-1:0]    slot_idx;
	logic             is_press;
	logic             plain;
	logic [MaskW-1:0] fresh;
	logic [MaskW-1:0] dying;
	logic [MaskW-1:0] half_press;
	logic [MaskW-1:0] full_press;
	logic [MaskW-1:0] half_rel;
	logic [MaskW-1:0] full_rel;
	logic [MaskW-1:0] scan_bits;
	logic             cork_press;
	logic             def_first_err;

	function automatic logic [KW-1:0] key_addr(input logic [KeyW-1:0] k);
		return (k < KeyLimit) ? k[KW-1:0] : '0;
	endfunction

	// Memory: one write port, front and back read ports, registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q      <= mem[raddr];
		back_rdata_q <= mem[back_raddr][MaskW-1:0];
	end

	assign back_rdata      = back_rdata_q;
	assign pair_first_key  = pair_first_q[back_combo];
	assign pair_second_key = pair_second_q[back_combo];

	// Classification of the item against the word just read
	assign word_pressed = rdata_q[MaskW];
	assign word_mask    = rdata_q[MaskW-1:0];
	assign key_ok       = key_q < KeyLimit;
	assign sec_ok       = second_q < KeyLimit;
	assign slot_ok      = {1'b0, slot_q} < SlotLimit;
	assign slot_bit     = MaskW'(1) << slot_q;
	assign slot_idx     = slot_q[CW-1:0];
	assign is_press     = op_q == OP_PRESS;
	assign plain        = !key_ok || (word_mask == '0) ||
	                      (is_press ? word_pressed : !word_pressed);
	assign fresh        = word_mask & half_q & ~full_q;
	assign half_press   = half_q | word_mask;
	assign full_press   = full_q | fresh;
	assign cork_press   = half_press != half_q;
	assign dying        = word_mask & full_q;
	assign full_rel     = full_q & ~dying;
	assign half_rel     = half_q & ~(word_mask & ~dying);
	assign scan_bits    = is_press ? fresh : dying;
	assign def_first_err = !slot_ok || ((alloc_q & slot_bit) != '0) || !key_ok ||
	                       ((word_mask & slot_bit) != '0);

	// Next state
	always_comb begin
		fst_d = fst_q;
		case (fst_q)
			F_IDLE: begin
				if (in_valid && in_ready) begin
					if (opcode == OP_DEFINE) begin
						fst_d = F_DEF;
					end else if (opcode == OP_PRESS || opcode == OP_RELEASE) begin
						fst_d = F_KEY;
					end
				end
			end
			F_KEY: begin
				if (!q_full) begin
					fst_d = F_IDLE;
				end
			end
			F_DEF: begin
				if (back_idle && !q_full) begin
					fst_d = def_first_err ? F_IDLE : F_DEF_RD;
				end
			end
			F_DEF_RD: begin
				fst_d = F_DEF_SEC;
			end
			F_DEF_SEC: begin
				if (!q_full) begin
					fst_d = F_IDLE;
				end
			end
			default: begin
				fst_d = F_IDLE;
			end
		endcase
	end

	// Outputs and state actions
	always_comb begin
		in_ready   = 1'b0;
		push       = 1'b0;
		job        = '0;
		job.kind   = JOB_SINGLE;
		we         = 1'b0;
		raddr      = key_addr(key_q);
		waddr      = key_addr(key_q);
		wdata      = rdata_q;
		set_alloc  = 1'b0;
		set_first  = 1'b0;
		set_second = 1'b0;
		set_masks  = 1'b0;
		half_d     = half_q;
		full_d     = full_q;
		case (fst_q)
			F_IDLE: begin
				in_ready = !clearing_q;
				raddr    = key_addr(key);
			end
			F_KEY: begin
				if (!q_full) begin
					push      = 1'b1;
					job.kind  = (plain || scan_bits == '0) ? JOB_SINGLE :
					            (is_press ? JOB_PRESS : JOB_RELEASE);
					job.key   = key_q;
					job.down  = is_press;
					job.cork  = plain ? 1'b0 : (is_press ? cork_press : (dying != '0));
					job.bits  = scan_bits;
					job.full  = full_rel;
					if (!plain) begin
						we        = 1'b1;
						wdata     = {is_press, word_mask};
						set_masks = 1'b1;
						half_d    = is_press ? half_press : half_rel;
						full_d    = is_press ? full_press : full_rel;
					end
				end
			end
			F_DEF: begin
				if (back_idle && !q_full) begin
					if (!slot_ok || (alloc_q & slot_bit) != '0) begin
						push       = 1'b1;
						job.status = ST_SLOT_USED;
					end else begin
						set_alloc = 1'b1;
						if (!key_ok) begin
							push       = 1'b1;
							job.status = ST_KEY_RANGE;
						end else if ((word_mask & slot_bit) != '0) begin
							push       = 1'b1;
							job.status = ST_SAME_KEY;
						end else begin
							we        = 1'b1;
							wdata     = {word_pressed, word_mask | slot_bit};
							set_first = 1'b1;
						end
					end
				end
			end
			F_DEF_RD: begin
				raddr = key_addr(second_q);
			end
			F_DEF_SEC: begin
				raddr = key_addr(second_q);
				waddr = key_addr(second_q);
				if (!q_full) begin
					push = 1'b1;
					if (!sec_ok) begin
						job.status = ST_KEY_RANGE;
					end else if ((word_mask & slot_bit) != '0) begin
						job.status = ST_SAME_KEY;
					end else begin
						job.status = ST_OK;
						we         = 1'b1;
						wdata      = {word_pressed, word_mask | slot_bit};
						set_second = 1'b1;
					end
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		// clearing pass after reset owns the write port
		if (clearing_q) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end
	end

	assign push_job = job;

	// Item capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= opcode;
			key_q    <= key;
			second_q <= second_key;
			slot_q   <= combo_index;
		end
	end

	// Control and combo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q      <= F_IDLE;
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			alloc_q    <= '0;
			half_q     <= '0;
			full_q     <= '0;
			for (int i = 0; i < NUM_COMBOS; i++) begin
				pair_first_q[i]  <= '0;
				pair_second_q[i] <= '0;
			end
		end else begin
			fst_q <= fst_d;
			if (clearing_q) begin
				if (clr_cnt_q == LastAddr) begin
					clearing_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
			end
			if (set_alloc) begin
				alloc_q <= alloc_q | slot_bit;
			end
			if (set_masks) begin
				half_q <= half_d;
				full_q <= full_d;
			end
			if (set_first) begin
				pair_first_q[slot_idx] <= key_q[KW-1:0];
			end
			if (set_second) begin
				pair_second_q[slot_idx] <= second_q[KW-1:0];
			end
		end
	end

`ifndef SYNTHESIS
	// define updates run only while the back end reads nothing
	a_def_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fst_q == F_DEF_RD || fst_q == F_DEF_SEC) |-> back_idle)
		else $error("define in progress while back end busy");
	// no item is taken before the clearing pass ends
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !clearing_q && fst_q == F_IDLE)
		else $error("item accepted during clearing or busy front");
`endif

endmodule

### sv/kcc_queue.sv
// Short job queue between front end and back end.
`timescale 1ns / 1ps

module kcc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kcc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output kcc_pkg::job_t head,
	output logic          empty
);
	import kcc_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

	job_t            entries_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = count_q == CntW'(QueueDepth);
	assign empty = count_q == '0;
	assign head  = entries_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job popped from empty queue");
`endif

endmodule

### sv/kcc_back.sv
// Back end: expands queued jobs into result items, one per cycle at most.
`timescale 1ns / 1ps

module kcc_back #(
	parameter int NUM_KEYS   = kcc_pkg::DefaultNumKeys,
	parameter int NUM_COMBOS = kcc_pkg::DefaultNumCombos
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         q_empty,
	input  kcc_pkg::job_t                                q_head,
	output logic                                         pop,
	output logic                                         back_idle,
	output logic [$clog2(NUM_KEYS)-1:0]                  mask_raddr,
	input  logic [kcc_pkg::MaskW-1:0]                    mask_rdata,
	output logic [((NUM_COMBOS > 1) ? $clog2(NUM_COMBOS) : 1)-1:0] combo,
	input  logic [$clog2(NUM_KEYS)-1:0]                  pair_first_key,
	input  logic [$clog2(NUM_KEYS)-1:0]                  pair_second_key,
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output logic [kcc_pkg::KeyW-1:0]                     event_number,
	output logic                                         is_down,
	output logic                                         cork,
	output logic [kcc_pkg::StatusW-1:0]                  status,
	output logic                                         last
);
	import kcc_pkg::*;

	localparam int CW = (NUM_COMBOS > 1) ? $clog2(NUM_COMBOS) : 1;
	localparam logic [KeyW-1:0] ComboBase = KeyW'(NUM_KEYS);
	localparam logic [KeyW-1:0] FoldLo    = KeyW'(65);
	localparam logic [KeyW-1:0] FoldHi    = KeyW'(90);
	localparam logic [KeyW-1:0] FoldOff   = KeyW'(32);

	back_state_t      bst_q, bst_d;
	job_t             job_q;
	logic [MaskW-1:0] rem_q;
	logic [CW-1:0]    c_q;
	logic             cond_a_q;
	logic             cond_b_q;

	logic             out_valid_q;
	logic [KeyW-1:0]  ev_q;
	logic             down_q;
	logic             cork_q;
	logic [StatusW-1:0] status_q;
	logic             last_q;

	logic             out_free;
	logic             emit;
	logic [KeyW-1:0]  emit_ev;
	logic             emit_down;
	logic             emit_last;
	logic [MaskW-1:0] lowbit;
	logic [CW-1:0]    next_c;
	logic             rem_zero;
	logic [KeyW-1:0]  pf_ext;
	logic [KeyW-1:0]  ps_ext;
	logic             pf_self;
	logic             ps_self;
	logic             cond_a_now;
	logic             cond_b_now;
	logic [KeyW-1:0]  combo_ev;

	// Lowest set bit to slot number: OR of the indexes, bits are independent
	function automatic logic [SlotW-1:0] onehot_index(input logic [MaskW-1:0] oh);
		logic [SlotW-1:0] idx;
		idx = '0;
		for (int i = 0; i < MaskW; i++) begin
			if (oh[i]) begin
				idx = idx | SlotW'(i);
			end
		end
		return idx;
	endfunction

	// Upper-case letter codes go out as lower case
	function automatic logic [KeyW-1:0] fold_case(input logic [KeyW-1:0] ev);
		return (ev >= FoldLo && ev <= FoldHi) ? ev + FoldOff : ev;
	endfunction

	// Partner key goes back down when still a combo key and no full combo holds it
	function automatic logic partner_down(input logic [KeyW-1:0] p,
	                                      input logic [MaskW-1:0] m,
	                                      input job_t j);
		return (p != j.key) && (m != '0) && ((j.full & m) == '0);
	endfunction

	assign out_free   = !out_valid_q || out_ready;
	assign lowbit     = rem_q & (~rem_q + MaskW'(1));
	assign next_c     = CW'(onehot_index(lowbit));
	assign rem_zero   = rem_q == '0;
	assign combo      = c_q;
	assign pf_ext     = KeyW'(pair_first_key);
	assign ps_ext     = KeyW'(pair_second_key);
	assign pf_self    = pf_ext == job_q.key;
	assign ps_self    = ps_ext == job_q.key;
	assign cond_a_now = partner_down(pf_ext, mask_rdata, job_q);
	assign cond_b_now = partner_down(ps_ext, mask_rdata, job_q);
	assign combo_ev   = ComboBase + KeyW'(c_q);
	assign back_idle  = (bst_q == B_IDLE) && q_empty;

	// Next state
	always_comb begin
		bst_d = bst_q;
		case (bst_q)
			B_IDLE: begin
				if (!q_empty) begin
					bst_d = (q_head.kind == JOB_SINGLE) ? B_ONE : B_NEXT;
				end
			end
			B_ONE: begin
				if (out_free) begin
					bst_d = B_IDLE;
				end
			end
			B_NEXT: begin
				bst_d = (job_q.kind == JOB_PRESS) ? B_P_FIRST : B_R_RDA;
			end
			B_P_FIRST: begin
				if (pf_self || out_free) begin
					bst_d = B_P_SECOND;
				end
			end
			B_P_SECOND: begin
				if (ps_self || out_free) begin
					bst_d = B_P_COMBO;
				end
			end
			B_P_COMBO: begin
				if (out_free) begin
					bst_d = rem_zero ? B_IDLE : B_NEXT;
				end
			end
			B_R_RDA: begin
				bst_d = B_R_RDB;
			end
			B_R_RDB: begin
				bst_d = B_R_COMBO;
			end
			B_R_COMBO: begin
				if (out_free) begin
					bst_d = B_R_A;
				end
			end
			B_R_A: begin
				if (!cond_a_q || out_free) begin
					bst_d = B_R_B;
				end
			end
			B_R_B: begin
				if (!cond_b_q || out_free) begin
					bst_d = rem_zero ? B_IDLE : B_NEXT;
				end
			end
			default: begin
				bst_d = B_IDLE;
			end
		endcase
	end

	// Outputs: pop, memory address and the result to emit
	always_comb begin
		pop        = 1'b0;
		emit       = 1'b0;
		emit_ev    = job_q.key;
		emit_down  = 1'b0;
		emit_last  = 1'b0;
		mask_raddr = (bst_q == B_R_RDA) ? pair_first_key : pair_second_key;
		case (bst_q)
			B_IDLE: begin
				pop = !q_empty;
			end
			B_ONE: begin
				emit      = out_free;
				emit_down = job_q.down;
				emit_last = 1'b1;
			end
			B_P_FIRST: begin
				emit    = out_free && !pf_self;
				emit_ev = pf_ext;
			end
			B_P_SECOND: begin
				emit    = out_free && !ps_self;
				emit_ev = ps_ext;
			end
			B_P_COMBO: begin
				emit      = out_free;
				emit_ev   = combo_ev;
				emit_down = 1'b1;
				emit_last = rem_zero;
			end
			B_R_COMBO: begin
				emit      = out_free;
				emit_ev   = combo_ev;
				emit_last = rem_zero && !cond_a_q && !cond_b_now;
			end
			B_R_A: begin
				emit      = out_free && cond_a_q;
				emit_ev   = pf_ext;
				emit_down = 1'b1;
				emit_last = rem_zero && !cond_b_q;
			end
			B_R_B: begin
				emit      = out_free && cond_b_q;
				emit_ev   = ps_ext;
				emit_down = 1'b1;
				emit_last = rem_zero;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Job and scan registers
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
			rem_q <= q_head.bits;
		end
		if (bst_q == B_NEXT) begin
			c_q   <= next_c;
			rem_q <= rem_q & ~lowbit;
		end
		if (bst_q == B_R_RDB) begin
			cond_a_q <= cond_a_now;
		end
		if (bst_q == B_R_COMBO && out_free) begin
			cond_b_q <= cond_b_now;
		end
		if (emit) begin
			ev_q     <= fold_case(emit_ev);
			down_q   <= emit_down;
			cork_q   <= job_q.cork;
			status_q <= job_q.status;
			last_q   <= emit_last;
		end
	end

	// Control state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			bst_q <= bst_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign event_number = ev_q;
	assign is_down      = down_q;
	assign cork         = cork_q;
	assign status       = status_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	// a define result with an error status is always a lone up item on event zero
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> last_q && !down_q && ev_q == '0)
		else $error("define status on a non-single result");
	// a scan never runs on an empty set of combo bits
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_head.kind != JOB_SINGLE) |-> q_head.bits != '0)
		else $error("scan job with no combo bits");
`endif

endmodule

### sv/key_chord_combo_detector.sv
// Key chord combo detector top level: front end, job queue, back end.
// Front end: takes a new item only in its idle state, once the last one is queued; a define
// also waits until the queue is empty and the back end is idle.
// Back end: pops a job, then emits one single result, or for each combo that completes or breaks
// the combo item and the items of its partner keys, plus any output stalls.
// Reset: asynchronous; a clearing pass then zeroes the key memory, in_ready low.
`timescale 1ns / 1ps

module key_chord_combo_detector #(
	parameter int NUM_KEYS   = kcc_pkg::DefaultNumKeys,
	parameter int NUM_COMBOS = kcc_pkg::DefaultNumCombos
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [kcc_pkg::OpW-1:0]      opcode,
	input  logic [kcc_pkg::KeyW-1:0]     key,
	input  logic [kcc_pkg::KeyW-1:0]     second_key,
	input  logic [kcc_pkg::SlotW-1:0]    combo_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [kcc_pkg::KeyW-1:0]     event_number,
	output logic                         is_down,
	output logic                         cork,
	output logic [kcc_pkg::StatusW-1:0]  status,
	output logic                         last
);
	import kcc_pkg::*;

	localparam int KW = $clog2(NUM_KEYS);
	localparam int CW = (NUM_COMBOS > 1) ? $clog2(NUM_COMBOS) : 1;

	logic             push;
	job_t             push_job;
	logic             q_full;
	logic             q_empty;
	job_t             q_head;
	logic             pop;
	logic             back_idle;
	logic [KW-1:0]    mask_raddr;
	logic [MaskW-1:0] mask_rdata;
	logic [CW-1:0]    combo;
	logic [KW-1:0]    pair_first_key;
	logic [KW-1:0]    pair_second_key;

	kcc_front #(
		.NUM_KEYS   (NUM_KEYS),
		.NUM_COMBOS (NUM_COMBOS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.key             (key),
		.second_key      (second_key),
		.combo_index     (combo_index),
		.push            (push),
		.push_job        (push_job),
		.q_full          (q_full),
		.back_idle       (back_idle),
		.back_raddr      (mask_raddr),
		.back_rdata      (mask_rdata),
		.back_combo      (combo),
		.pair_first_key  (pair_first_key),
		.pair_second_key (pair_second_key)
	);

	kcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	kcc_back #(
		.NUM_KEYS   (NUM_KEYS),
		.NUM_COMBOS (NUM_COMBOS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_head          (q_head),
		.pop             (pop),
		.back_idle       (back_idle),
		.mask_raddr      (mask_raddr),
		.mask_rdata      (mask_rdata),
		.combo           (combo),
		.pair_first_key  (pair_first_key),
		.pair_second_key (pair_second_key),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_number    (event_number),
		.is_down         (is_down),
		.cork            (cork),
		.status          (status),
		.last            (last)
	);

endmodule
